@@ rtl/utcd_pkg.sv @@
package utcd_pkg;

	localparam int unsigned ALU_W  = 32;
	localparam int unsigned DAYS_W = 16;
	localparam int unsigned YEAR_W = 12;
	localparam int unsigned CNT_W  = 4;

	localparam logic [ALU_W-1:0] DAY_SECS  = 32'd86400;
	localparam logic [ALU_W-1:0] HOUR_SECS = 32'd3600;
	localparam logic [ALU_W-1:0] MIN_SECS  = 32'd60;

	// Quotient widths less one: days < 2^16, hours < 2^5, minutes < 2^6.
	localparam logic [CNT_W-1:0] DAY_STEPS  = 4'd15;
	localparam logic [CNT_W-1:0] HOUR_STEPS = 4'd4;
	localparam logic [CNT_W-1:0] MIN_STEPS  = 4'd5;

	localparam logic [ALU_W-1:0] DAY_DVS  = DAY_SECS << 15;
	localparam logic [ALU_W-1:0] HOUR_DVS = HOUR_SECS << 4;
	localparam logic [ALU_W-1:0] MIN_DVS  = MIN_SECS << 5;

	localparam logic [YEAR_W-1:0] EPOCH_YEAR = 12'd1970;
	localparam logic [1:0] EPOCH_MOD4   = 2'd2;
	localparam logic [6:0] EPOCH_MOD100 = 7'd70;
	localparam logic [8:0] EPOCH_MOD400 = 9'd370;

	localparam logic [8:0] DAYS_LEAP   = 9'd366;
	localparam logic [8:0] DAYS_COMMON = 9'd365;

	localparam logic [3:0] MONTH_JAN  = 4'd0;
	localparam logic [3:0] MONTH_FEB  = 4'd1;
	localparam logic [3:0] MONTH_APR  = 4'd3;
	localparam logic [3:0] MONTH_JUN  = 4'd5;
	localparam logic [3:0] MONTH_SEP  = 4'd8;
	localparam logic [3:0] MONTH_NOV  = 4'd10;
	localparam logic [3:0] MONTH_LAST = 4'd11;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DAY   = 6'b000010,
		ST_HOUR  = 6'b000100,
		ST_MIN   = 6'b001000,
		ST_YEAR  = 6'b010000,
		ST_MONTH = 6'b100000
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} year_ctrl_t;

	function automatic logic [4:0] month_days(input logic leap, input logic [3:0] month);
		logic [4:0] len;
		case (month)
			MONTH_FEB: len = leap ? 5'd29 : 5'd28;
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

@@ rtl/unix_time_to_calendar_date.sv @@
// After acceptance the sequencer divides out days, then hours, then minutes, then
// removes whole years from 1970 and then whole months, and raises done at the end.
// Throughput: one transaction at a time; busy stays high until the strobe cycle,
// set by one shared subtract/compare unit walked through division, year and month steps.
// Results show for one cycle with done high; the receiver cannot stall them.
// Reset (arst_n low, asynchronous) returns the sequencer to idle and drops done.
module unix_time_to_calendar_date
	import utcd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] epoch_seconds,
	output logic        done,
	output logic [5:0]  sec_of_minute,
	output logic [5:0]  min_of_hour,
	output logic [4:0]  hour_of_day,
	output logic [4:0]  day_of_month,
	output logic [3:0]  month_of_year,
	output logic [11:0] calendar_year
);

	state_t             state_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ALU_W-1:0]   rem_q;      // running remainder of the seconds divisions
	logic [ALU_W-1:0]   dvs_q;      // divisor, shifted right one place per step
	logic [DAYS_W-1:0]  days_q;     // day quotient, then days left in year/month
	logic [4:0]         hour_q;
	logic [5:0]         min_q;
	logic [3:0]         mon_q;

	logic [ALU_W-1:0]   alu_a;
	logic [ALU_W-1:0]   alu_b;
	logic [ALU_W-1:0]   alu_diff;
	logic               alu_ge;
	logic               accept;
	logic               leap;
	logic [YEAR_W-1:0]  year;
	year_ctrl_t         year_ctrl;

	assign accept = start && (state_q == ST_IDLE);

	// Steer the shared unit: divisions use the remainder and shifted divisor,
	// the calendar walk uses the day count against a year or month length.
	always_comb begin
		case (state_q)
			ST_YEAR: begin
				alu_a = {{(ALU_W-DAYS_W){1'b0}}, days_q};
				alu_b = {{(ALU_W-9){1'b0}}, (leap ? DAYS_LEAP : DAYS_COMMON)};
			end
			ST_MONTH: begin
				alu_a = {{(ALU_W-DAYS_W){1'b0}}, days_q};
				alu_b = {{(ALU_W-5){1'b0}}, month_days(leap, mon_q)};
			end
			default: begin
				alu_a = rem_q;
				alu_b = dvs_q;
			end
		endcase
	end

	utcd_alu u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.diff (alu_diff),
		.ge   (alu_ge)
	);

	// Restart the year counter on a new transaction; advance it per whole year removed.
	assign year_ctrl.load = accept;
	assign year_ctrl.step = (state_q == ST_YEAR) && alu_ge;

	utcd_year u_year (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (year_ctrl),
		.year   (year),
		.leap   (leap)
	);

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DAY;
						cnt_q   <= DAY_STEPS;
					end
				end
				ST_DAY: begin
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == '0) begin
						state_q <= ST_HOUR;
						cnt_q   <= HOUR_STEPS;
					end
				end
				ST_HOUR: begin
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == '0) begin
						state_q <= ST_MIN;
						cnt_q   <= MIN_STEPS;
					end
				end
				ST_MIN: begin
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == '0) begin
						state_q <= ST_YEAR;
					end
				end
				ST_YEAR: begin
					// Stop once fewer days remain than this year holds.
					if (!alu_ge) begin
						state_q <= ST_MONTH;
					end
				end
				ST_MONTH: begin
					// December takes whatever is left; otherwise stop on a short remainder.
					if (!alu_ge || (mon_q == MONTH_LAST)) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					rem_q  <= epoch_seconds;
					dvs_q  <= DAY_DVS;
					days_q <= '0;
				end
			end
			ST_DAY: begin
				if (alu_ge) begin
					rem_q <= alu_diff;
				end
				days_q <= {days_q[DAYS_W-2:0], alu_ge};
				dvs_q  <= (cnt_q == '0) ? HOUR_DVS : (dvs_q >> 1);
				hour_q <= '0;
			end
			ST_HOUR: begin
				if (alu_ge) begin
					rem_q <= alu_diff;
				end
				hour_q <= {hour_q[3:0], alu_ge};
				dvs_q  <= (cnt_q == '0) ? MIN_DVS : (dvs_q >> 1);
				min_q  <= '0;
			end
			ST_MIN: begin
				if (alu_ge) begin
					rem_q <= alu_diff;
				end
				min_q <= {min_q[4:0], alu_ge};
				dvs_q <= dvs_q >> 1;
				mon_q <= MONTH_JAN;
			end
			ST_YEAR: begin
				if (alu_ge) begin
					days_q <= alu_diff[DAYS_W-1:0];
				end
			end
			ST_MONTH: begin
				if (alu_ge && (mon_q != MONTH_LAST)) begin
					days_q <= alu_diff[DAYS_W-1:0];
					mon_q  <= mon_q + 4'd1;
				end
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign sec_of_minute = rem_q[5:0];
	assign min_of_hour   = min_q;
	assign hour_of_day   = hour_q;
	assign day_of_month  = days_q[4:0] + 5'd1;
	assign month_of_year = mon_q + 4'd1;
	assign calendar_year = year;

endmodule

@@ rtl/utcd_alu.sv @@
module utcd_alu
	import utcd_pkg::*;
(
	input  logic [ALU_W-1:0] a,
	input  logic [ALU_W-1:0] b,
	output logic [ALU_W-1:0] diff,
	output logic             ge
);

	logic [ALU_W:0] full;

	// One subtractor: the borrow out is the compare.
	assign full = {1'b0, a} - {1'b0, b};
	assign diff = full[ALU_W-1:0];
	assign ge   = ~full[ALU_W];

endmodule

@@ rtl/utcd_year.sv @@
module utcd_year
	import utcd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  year_ctrl_t        ctrl,
	output logic [YEAR_W-1:0] year,
	output logic              leap
);

	logic [YEAR_W-1:0] year_q;
	logic [1:0]        mod4_q;
	logic [6:0]        mod100_q;
	logic [8:0]        mod400_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q   <= EPOCH_YEAR;
			mod4_q   <= EPOCH_MOD4;
			mod100_q <= EPOCH_MOD100;
			mod400_q <= EPOCH_MOD400;
		end else if (ctrl.load) begin
			year_q   <= EPOCH_YEAR;
			mod4_q   <= EPOCH_MOD4;
			mod100_q <= EPOCH_MOD100;
			mod400_q <= EPOCH_MOD400;
		end else if (ctrl.step) begin
			year_q   <= year_q + 12'd1;
			mod4_q   <= mod4_q + 2'd1;
			mod100_q <= (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
			mod400_q <= (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
		end
	end

	assign year = year_q;
	assign leap = ((mod4_q == 2'd0) && (mod100_q != 7'd0)) || (mod400_q == 9'd0);

endmodule

@@ rtl/utcd_chk.sv @@
module utcd_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [5:0]  sec_of_minute,
	input logic [5:0]  min_of_hour,
	input logic [4:0]  hour_of_day,
	input logic [4:0]  day_of_month,
	input logic [3:0]  month_of_year,
	input logic [11:0] calendar_year
);

	// A transaction taken always makes the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");

	// The strobe comes only as the block goes idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("done without a finished transaction");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (sec_of_minute < 6'd60) && (min_of_hour < 6'd60) && (hour_of_day < 5'd24))
		else $error("time of day out of range");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (month_of_year >= 4'd1) && (month_of_year <= 4'd12) &&
			(day_of_month != 5'd0) && (calendar_year >= 12'd1970) &&
			(calendar_year <= 12'd2106))
		else $error("calendar date out of range");

endmodule

bind unix_time_to_calendar_date utcd_chk u_chk (.*);
